// ===== rtl/bpfa_pkg.sv =====
// bpfa_pkg: shared constants, codes and controller/datapath interface types
// for the bitmap page frame allocator; no dependencies
package bpfa_pkg;

    localparam int FRAME_COUNT = 65536;
    localparam int WORD_BITS   = 32;
    localparam int NUM_WORDS   = FRAME_COUNT / WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WIDX_W      = $clog2(NUM_WORDS);
    localparam int FIDX_W      = WIDX_W + BIT_W;

    localparam int OPCODE_W    = 2;
    localparam int FRAME_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int SUM_W       = COUNT_W + 1;
    localparam int LIMIT_W     = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int LIMIT_RESET = 2048;

    typedef logic [OPCODE_W-1:0]  t_opcode;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_opcode OP_ALLOC      = 2'd0;
    localparam t_opcode OP_FREE       = 2'd1;
    localparam t_opcode OP_RANGE_FREE = 2'd2;
    localparam t_opcode OP_RANGE_RSV  = 2'd3;

    localparam t_cfg_idx CFG_LIMIT = 2'd0;
    localparam t_cfg_idx CFG_START = 2'd1;

    typedef struct packed {
        logic load;
        logic issue;
        logic modify;
        logic clear;
        logic present;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
        logic done_word;
        logic empty;
        logic clr_last;
    } t_dp_stat;

endpackage

// ===== rtl/bitmap_page_frame_allocator.sv =====
// bitmap_page_frame_allocator: top level, joins bpfa_ctrl and bpfa_dp
// uses bpfa_pkg, bpfa_ctrl, bpfa_dp
//
// After reset the block stalls its input while it clears the bitmap to all
// reserved (configuration writes are taken meanwhile). Each request is then
// accepted, visits its bitmap words and posts its result: an allocation
// hitting at the hint visits one word, a free visits one word, a range
// visits every word it spans, an allocation that misses visits the words
// scanned. Words are visited through the single read and write port of the
// bitmap memory, one word per cycle. One request is worked at a time; a
// finished result waits in the output register while the next request is
// accepted.
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [FRAME_W-1:0]    i_frame,
    input  logic [COUNT_W-1:0]    i_count,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FRAME_W-1:0]    o_frame_out,
    output logic                  o_found,
    output logic                  o_out_of_range,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bpfa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_opcode       (i_opcode),
        .i_frame        (i_frame),
        .i_count        (i_count),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_frame_out    (o_frame_out),
        .o_found        (o_found),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// ===== rtl/bpfa_ctrl.sv =====
// bpfa_ctrl: sequencing state machine for the allocator, drives datapath
// commands and the input/output handshakes; uses bpfa_pkg
module bpfa_ctrl
    import bpfa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_POST
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load    = w_accept;
        o_cmd.clear   = (r_state == S_CLEAR);
        o_cmd.issue   = (r_state == S_RUN);
        o_cmd.modify  = (r_state == S_RUN);
        o_cmd.present = (r_state == S_POST) && w_out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.empty || i_stat.done_word) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.present ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_state == S_CLEAR))
        else $error("reset does not start the clearing pass");

    a_post_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && w_out_free) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not presented after post");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result word dropped");

endmodule

// ===== rtl/bpfa_dp.sv =====
// bpfa_dp: bitmap memory, scan and range address counters, word modify logic,
// search hint, configuration and result registers; uses bpfa_pkg
module bpfa_dp
    import bpfa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [FRAME_W-1:0]    i_frame,
    input  logic [COUNT_W-1:0]    i_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [FRAME_W-1:0]    o_frame_out,
    output logic                  o_found,
    output logic                  o_out_of_range
);

    localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] n;
        n = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (v[k]) begin
                n = BIT_W'(k);
            end
        end
        return n;
    endfunction

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;
    logic [WIDX_W:0]      r_iaddr;
    logic [WIDX_W:0]      r_daddr;
    logic                 r_rvld;
    logic [WIDX_W-1:0]    r_first;
    logic [WIDX_W-1:0]    r_last;
    logic [WIDX_W-1:0]    r_hint;
    logic [WIDX_W-1:0]    r_clr;
    logic [BIT_W-1:0]     r_lo;
    logic [BIT_W-1:0]     r_hi;
    logic                 r_scan;
    logic                 r_set;
    logic                 r_empty;
    logic [LIMIT_W-1:0]   r_limit;
    logic [FRAME_W-1:0]   r_res_frame;
    logic                 r_res_found;
    logic                 r_res_oor;
    logic [FRAME_W-1:0]   r_out_frame;
    logic                 r_out_found;
    logic                 r_out_oor;

    logic [SUM_W-1:0]     w_sum;
    logic [SUM_W-1:0]     w_end;
    logic [FIDX_W-1:0]    w_lastf;
    logic                 w_rng_oor;
    logic                 w_frame_oor;
    logic [WIDX_W-1:0]    w_ld_word;
    logic [WIDX_W:0]      w_lim;
    logic                 w_scan_empty;
    logic                 w_more;
    logic                 w_at_first;
    logic                 w_at_last;
    logic [BIT_W-1:0]     w_lo;
    logic [BIT_W-1:0]     w_hi;
    logic [WORD_BITS-1:0] w_mask;
    logic                 w_hit;
    logic [BIT_W-1:0]     w_bit;
    logic                 w_scan_hit;
    logic                 w_we;
    logic [WIDX_W-1:0]    w_waddr;
    logic [WORD_BITS-1:0] w_wdata;

    // request decode
    assign w_sum        = SUM_W'(i_frame) + SUM_W'(i_count);
    assign w_frame_oor  = (SUM_W'(i_frame) >= SUM_W'(FRAME_COUNT));
    assign w_rng_oor    = (i_count != '0) && (w_sum > SUM_W'(FRAME_COUNT));
    assign w_end        = w_rng_oor ? SUM_W'(FRAME_COUNT) : w_sum;
    assign w_lastf      = FIDX_W'(w_end - SUM_W'(1));
    assign w_ld_word    = WIDX_W'(i_frame >> BIT_W);
    assign w_lim        = (32'(r_limit) > 32'(NUM_WORDS)) ? (WIDX_W + 1)'(NUM_WORDS)
                                                         : (WIDX_W + 1)'(r_limit);
    assign w_scan_empty = ({1'b0, r_hint} >= w_lim);

    // word modify
    assign w_more     = !r_empty && (r_iaddr <= {1'b0, r_last});
    assign w_at_first = (r_daddr[WIDX_W-1:0] == r_first);
    assign w_at_last  = (r_daddr[WIDX_W-1:0] == r_last);
    assign w_lo       = w_at_first ? r_lo : '0;
    assign w_hi       = w_at_last ? r_hi : BIT_W'(WORD_BITS - 1);
    assign w_mask     = (WORD_ONES << w_lo) & (WORD_ONES >> (BIT_W'(WORD_BITS - 1) - w_hi));
    assign w_hit      = (r_rdata != '0);
    assign w_bit      = lowest_set(r_rdata);
    assign w_scan_hit = i_cmd.modify && r_rvld && r_scan && w_hit;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_daddr[WIDX_W-1:0];
        w_wdata = r_set ? (r_rdata | w_mask) : (r_rdata & ~w_mask);
        if (i_cmd.clear) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (i_cmd.modify && r_rvld) begin
            if (r_scan) begin
                w_we    = w_hit;
                w_wdata = r_rdata & (r_rdata - WORD_BITS'(1));
            end else begin
                w_we = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat           = '0;
        o_stat.more      = w_more;
        o_stat.done_word = r_rvld && ((r_scan && w_hit) || w_at_last);
        o_stat.empty     = r_empty;
        o_stat.clr_last  = (r_clr == WIDX_W'(NUM_WORDS - 1));
    end

    // bitmap store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_iaddr[WIDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_rvld  <= 1'b0;
            r_hint  <= '0;
            r_limit <= LIMIT_W'(LIMIT_RESET);
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + WIDX_W'(1);
            end
            r_rvld <= i_cmd.issue && w_more;
            if (i_cfg_we && i_cfg_index == CFG_LIMIT) begin
                r_limit <= LIMIT_W'(i_cfg_data);
            end
            if (i_cfg_we && i_cfg_index == CFG_START) begin
                r_hint <= WIDX_W'(i_cfg_data);
            end else if (w_scan_hit) begin
                r_hint <= r_daddr[WIDX_W-1:0];
            end else if (i_cmd.load && i_opcode == OP_FREE && !w_frame_oor
                         && w_ld_word < r_hint) begin
                r_hint <= w_ld_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_daddr <= r_iaddr;
        if (i_cmd.issue && w_more) begin
            r_iaddr <= r_iaddr + (WIDX_W + 1)'(1);
        end
        if (i_cmd.load) begin
            r_scan      <= (i_opcode == OP_ALLOC);
            r_set       <= (i_opcode != OP_RANGE_RSV);
            r_res_frame <= '0;
            r_res_found <= 1'b0;
            case (i_opcode)
                OP_ALLOC: begin
                    r_first   <= r_hint;
                    r_last    <= WIDX_W'(w_lim - (WIDX_W + 1)'(1));
                    r_iaddr   <= {1'b0, r_hint};
                    r_lo      <= '0;
                    r_hi      <= '0;
                    r_empty   <= w_scan_empty;
                    r_res_oor <= 1'b0;
                end
                OP_FREE: begin
                    r_first   <= w_ld_word;
                    r_last    <= w_ld_word;
                    r_iaddr   <= {1'b0, w_ld_word};
                    r_lo      <= i_frame[BIT_W-1:0];
                    r_hi      <= i_frame[BIT_W-1:0];
                    r_empty   <= w_frame_oor;
                    r_res_oor <= w_frame_oor;
                end
                default: begin
                    r_first   <= w_ld_word;
                    r_last    <= w_lastf[FIDX_W-1:BIT_W];
                    r_iaddr   <= {1'b0, w_ld_word};
                    r_lo      <= i_frame[BIT_W-1:0];
                    r_hi      <= w_lastf[BIT_W-1:0];
                    r_empty   <= (i_count == '0) || w_frame_oor;
                    r_res_oor <= w_rng_oor;
                end
            endcase
        end else if (w_scan_hit) begin
            r_res_frame <= FRAME_W'({r_daddr[WIDX_W-1:0], w_bit});
            r_res_found <= 1'b1;
        end
        if (i_cmd.present) begin
            r_out_frame <= r_res_frame;
            r_out_found <= r_res_found;
            r_out_oor   <= r_res_oor;
        end
    end

    assign o_frame_out    = r_out_frame;
    assign o_found        = r_out_found;
    assign o_out_of_range = r_out_oor;

    a_scan_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_scan && !i_cmd.clear) |-> ($countones(w_wdata) + 1 == $countones(r_rdata)))
        else $error("allocation write does not clear exactly one bit");

    a_range_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !r_scan && !i_cmd.clear) |-> (((w_wdata ^ r_rdata) & ~w_mask) == '0))
        else $error("range write touches bits outside its mask");

    a_read_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rvld && i_cmd.modify) |-> (r_daddr <= {1'b0, r_last}))
        else $error("word read beyond the last word of the request");

endmodule
